// ===== design/rppp_pkg.sv =====
package rppp_pkg;

	localparam int MAX_POINTS_DEF  = 64;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam int HEADER_BYTES = 4;
	localparam int RECORD_BYTES = 16;
	localparam int KEPT_BYTES   = 10;

	localparam int BYTE_IDX_W = 4;
	localparam int REC_IDX_W  = 7;
	localparam int REC_NUM_W  = 6;
	localparam int COUNT_W    = 32;
	localparam int CFG_IDX_W  = 2;

	localparam logic [REC_IDX_W-1:0] REC_IDX_MAX = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_RANGE = 2'd0,
		REG_MIN_SPEED = 2'd1
	} cfg_reg_t;

	// one classified transaction from the byte parser to the filter
	typedef struct packed {
		logic                 cand;
		logic                 frame_end;
		logic [15:0]          point_id;
		logic signed [15:0]   range_cm;
		logic signed [15:0]   velocity_cm;
		logic signed [15:0]   azimuth_cdeg;
		logic [15:0]          power_cdbm;
		logic [REC_NUM_W-1:0] record_number;
	} item_t;

endpackage

// ===== design/rppp_front.sv =====
module rppp_front #(
	parameter int MAX_POINTS = rppp_pkg::MAX_POINTS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [7:0]          data_byte,
	input  logic                last_byte,
	output logic                item_wr,
	output rppp_pkg::item_t     item
);

	logic                                header_done_q;
	logic [rppp_pkg::BYTE_IDX_W-1:0]     byte_index_q;
	logic [rppp_pkg::COUNT_W-1:0]        reported_count_q;
	logic [rppp_pkg::REC_IDX_W-1:0]      record_index_q;
	logic [7:0]                          rec_q [rppp_pkg::KEPT_BYTES];

	logic                                header_done_d;
	logic [rppp_pkg::BYTE_IDX_W-1:0]     byte_index_d;
	logic [rppp_pkg::COUNT_W-1:0]        reported_count_d;
	logic [rppp_pkg::REC_IDX_W-1:0]      record_index_d;
	logic                                rec_end;
	logic                                in_cap;
	logic                                rec_wr;

	assign rec_end = header_done_q &&
		(byte_index_q == rppp_pkg::BYTE_IDX_W'(rppp_pkg::RECORD_BYTES - 1));
	assign rec_wr  = header_done_q &&
		(byte_index_q < rppp_pkg::BYTE_IDX_W'(rppp_pkg::KEPT_BYTES));

	// record position below both the reported count and the cap
	assign in_cap = ((reported_count_q[rppp_pkg::COUNT_W-1:rppp_pkg::REC_IDX_W] != '0) ||
		(record_index_q < reported_count_q[rppp_pkg::REC_IDX_W-1:0])) &&
		(record_index_q < rppp_pkg::REC_IDX_W'(MAX_POINTS));

	always_comb begin
		header_done_d    = header_done_q;
		byte_index_d     = byte_index_q;
		reported_count_d = reported_count_q;
		record_index_d   = record_index_q;
		if (!header_done_q) begin
			reported_count_d = reported_count_q |
				(rppp_pkg::COUNT_W'(data_byte) << {byte_index_q[1:0], 3'b000});
			if (byte_index_q == rppp_pkg::BYTE_IDX_W'(rppp_pkg::HEADER_BYTES - 1)) begin
				header_done_d = 1'b1;
				byte_index_d  = '0;
			end else begin
				byte_index_d = byte_index_q + 1'b1;
			end
		end else if (rec_end) begin
			byte_index_d = '0;
			if (record_index_q != rppp_pkg::REC_IDX_MAX) begin
				record_index_d = record_index_q + 1'b1;
			end
		end else begin
			byte_index_d = byte_index_q + 1'b1;
		end
		if (last_byte) begin
			header_done_d    = 1'b0;
			byte_index_d     = '0;
			reported_count_d = '0;
			record_index_d   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_done_q    <= 1'b0;
			byte_index_q     <= '0;
			reported_count_q <= '0;
			record_index_q   <= '0;
		end else if (accept) begin
			header_done_q    <= header_done_d;
			byte_index_q     <= byte_index_d;
			reported_count_q <= reported_count_d;
			record_index_q   <= record_index_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && rec_wr) begin
			rec_q[byte_index_q] <= data_byte;
		end
	end

	assign item_wr = accept && ((rec_end && in_cap) || last_byte);

	always_comb begin
		item.cand          = rec_end && in_cap;
		item.frame_end     = last_byte;
		item.point_id      = {rec_q[1], rec_q[0]};
		item.range_cm      = {rec_q[3], rec_q[2]};
		item.velocity_cm   = {rec_q[5], rec_q[4]};
		item.azimuth_cdeg  = {rec_q[7], rec_q[6]};
		item.power_cdbm    = {rec_q[9], rec_q[8]};
		item.record_number = record_index_q[rppp_pkg::REC_NUM_W-1:0];
	end

`ifndef SYNTHESIS
	a_header_pos: assert property (@(posedge clk) disable iff (!arst_n)
		!header_done_q |-> byte_index_q < rppp_pkg::BYTE_IDX_W'(rppp_pkg::HEADER_BYTES))
		else $error("header byte position out of range");

	a_frame_clear: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last_byte |=> !header_done_q && record_index_q == '0 &&
		byte_index_q == '0 && reported_count_q == '0)
		else $error("parse state not cleared after last byte");
`endif

endmodule

// ===== design/rppp_fifo.sv =====
module rppp_fifo #(
	parameter int DEPTH = rppp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  rppp_pkg::item_t  wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic             rd_valid,
	output rppp_pkg::item_t  rd_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	rppp_pkg::item_t   mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count above depth");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> count_q != '0)
		else $error("read from empty queue");
`endif

endmodule

// ===== design/rppp_back.sv =====
module rppp_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr,
	input  logic [rppp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                    cfg_data,
	input  logic                           item_valid,
	input  rppp_pkg::item_t                item,
	output logic                           item_rd,
	output logic                           empty,
	input  logic                           pop,
	output logic                           point_valid,
	output logic                           frame_end,
	output logic [15:0]                    point_id,
	output logic signed [15:0]             range_cm,
	output logic signed [15:0]             velocity_cm,
	output logic signed [15:0]             azimuth_cdeg,
	output logic [15:0]                    power_cdbm,
	output logic [rppp_pkg::REC_NUM_W-1:0] record_number
);

	logic signed [15:0] min_range_q;
	logic [15:0]        min_speed_q;

	logic               out_valid_q;
	rppp_pkg::item_t    out_q;

	logic [16:0]        vel_mag;
	logic               kept;
	logic               emit;
	rppp_pkg::item_t    res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_range_q <= '0;
			min_speed_q <= '0;
		end else if (cfg_wr) begin
			case (rppp_pkg::cfg_reg_t'(cfg_index))
				rppp_pkg::REG_MIN_RANGE: min_range_q <= cfg_data;
				rppp_pkg::REG_MIN_SPEED: min_speed_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// magnitude needs 17 bits so that -32768 maps to 32768
	assign vel_mag = item.velocity_cm[15] ? (17'd0 - {1'b1, item.velocity_cm})
		: {1'b0, item.velocity_cm};
	assign kept = item.cand && (item.range_cm >= min_range_q) &&
		(vel_mag >= {1'b0, min_speed_q});
	assign emit = kept || item.frame_end;

	always_comb begin
		res = item;
		res.cand = kept;
		if (!kept) begin
			res.point_id      = '0;
			res.range_cm      = '0;
			res.velocity_cm   = '0;
			res.azimuth_cdeg  = '0;
			res.power_cdbm    = '0;
			res.record_number = '0;
		end
	end

	assign item_rd = item_valid && (!out_valid_q || pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (item_rd) begin
			out_valid_q <= emit;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_rd) begin
			out_q <= res;
		end
	end

	assign empty         = !out_valid_q;
	assign point_valid   = out_q.cand;
	assign frame_end     = out_q.frame_end;
	assign point_id      = out_q.point_id;
	assign range_cm      = out_q.range_cm;
	assign velocity_cm   = out_q.velocity_cm;
	assign azimuth_cdeg  = out_q.azimuth_cdeg;
	assign power_cdbm    = out_q.power_cdbm;
	assign record_number = out_q.record_number;

`ifndef SYNTHESIS
	a_drop_only_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.cand |-> out_q.frame_end)
		else $error("result with neither point nor frame end");

	a_kept_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.cand && !$past(cfg_wr) |-> out_q.range_cm >= min_range_q)
		else $error("kept point below minimum range");
`endif

endmodule

// ===== design/radar_point_packet_parser_unit.sv =====
// path: a record's final byte or the last byte queues an item, which then moves to the result register
// throughput: one byte per cycle while full is low; a stalled result side backs up through the result
//   register and the classified-item queue before full rises
// reset: arst_n asynchronous active low; clears parse counters, queue and thresholds,
//   record byte storage is not cleared
module radar_point_packet_parser_unit #(
	parameter int MAX_POINTS  = rppp_pkg::MAX_POINTS_DEF,
	parameter int QUEUE_DEPTH = rppp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic [7:0]                     data_byte,
	input  logic                           last_byte,
	output logic                           empty,
	input  logic                           pop,
	output logic                           point_valid,
	output logic                           frame_end,
	output logic [15:0]                    point_id,
	output logic signed [15:0]             range_cm,
	output logic signed [15:0]             velocity_cm,
	output logic signed [15:0]             azimuth_cdeg,
	output logic [15:0]                    power_cdbm,
	output logic [rppp_pkg::REC_NUM_W-1:0] record_number,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rppp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                    cfg_data
);

	logic            accept;
	logic            item_wr;
	rppp_pkg::item_t item_in;
	logic            item_rd;
	logic            item_valid;
	rppp_pkg::item_t item_out;

	assign accept    = push && !full;
	assign cfg_ready = 1'b1;

	rppp_front #(
		.MAX_POINTS(MAX_POINTS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.item_wr  (item_wr),
		.item     (item_in)
	);

	rppp_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (item_wr),
		.wr_data (item_in),
		.full    (full),
		.rd_en   (item_rd),
		.rd_valid(item_valid),
		.rd_data (item_out)
	);

	rppp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item         (item_out),
		.item_rd      (item_rd),
		.empty        (empty),
		.pop          (pop),
		.point_valid  (point_valid),
		.frame_end    (frame_end),
		.point_id     (point_id),
		.range_cm     (range_cm),
		.velocity_cm  (velocity_cm),
		.azimuth_cdeg (azimuth_cdeg),
		.power_cdbm   (power_cdbm),
		.record_number(record_number)
	);

endmodule
